/* rtl/mst_pkg.sv */
// Package for the multiset table: depths, widths, command codes, FSM states.
// No dependencies.
package mst_pkg;
    localparam int DistinctDepth = 128;
    localparam int TotalDepth    = 256;
    localparam int SlotW  = $clog2(DistinctDepth);
    localparam int OccW   = $clog2(TotalDepth);
    localparam int DCntW  = $clog2(DistinctDepth + 1);
    localparam int TCntW  = $clog2(TotalDepth + 1);

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_COUNT  = 3'd3,
        CMD_RANGE  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VSCAN,   // walk value store
        ST_VLAST,   // last value read returns
        ST_OSCAN,   // walk occurrence list
        ST_OLAST,
        ST_MOVE,    // read last occurrence for remove
        ST_MOVEW,
        ST_CSCAN,   // count remaining after remove
        ST_CLAST,
        ST_DONE
    } t_state;
endpackage

/* rtl/mst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mst_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/multiset_table_core.sv */
// Multiset table core: value store and occurrence list in two RAMs,
// sequenced by one FSM. Depends on mst_pkg and mst_ram.
// Each command scans the value store over all slots handed out so far; count and
// remove of a present value then scan the occurrence list (remove also rescans).
// One transaction at a time: o_ready returns the cycle after the result is taken.
// Reset clears the size, high-water mark and present bits; RAM contents stay.
module multiset_table_core
    import mst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_operand_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [8:0]         o_occurrences,
    output logic [8:0]         o_total_size,
    output logic               o_is_empty,
    output logic signed [32:0] o_value_range,
    output logic               o_add_dropped
);
    t_state r_state, n_state;
    logic [2:0]  r_cmd;
    logic [31:0] r_val;
    logic [DistinctDepth-1:0] r_present;
    logic [DCntW-1:0] r_used;
    logic [TCntW-1:0] r_total;
    logic [DCntW-1:0] r_vi;          // value scan index
    logic [TCntW-1:0] r_oi;          // occurrence scan index
    logic [DCntW-1:0] r_vq;          // index of value read in flight
    logic [TCntW-1:0] r_oq;
    logic        r_found;
    logic [SlotW-1:0] r_slot;
    logic        r_free_ok;
    logic [SlotW-1:0] r_free;
    logic [31:0] r_lo, r_hi;
    logic        r_any;
    logic [TCntW-1:0] r_cnt;
    logic [OccW-1:0] r_pos;          // first matching occurrence
    logic        r_ovalid;
    logic        r_ohit, r_odrop;
    logic [8:0]  r_oocc;
    logic [32:0] r_orange;

    logic             v_we;
    logic [SlotW-1:0] v_wa, v_ra;
    logic [31:0]      v_wd, v_rd;
    logic             o_we;
    logic [OccW-1:0]  o_wa, o_ra;
    logic [SlotW-1:0] o_wd, o_rd;

    mst_ram #(.Width(32), .Depth(DistinctDepth)) u_vals (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));
    mst_ram #(.Width(SlotW), .Depth(TotalDepth)) u_occs (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_wa), .i_wdata(o_wd),
        .i_raddr(o_ra), .o_rdata(o_rd));

    // Accept a new transaction only when idle and the result slot is empty.
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    wire accept = i_valid && o_ready;
    wire vq_ok  = r_vq < r_used;
    wire [SlotW-1:0] vq_s = r_vq[SlotW-1:0];
    wire vmatch = vq_ok && r_present[vq_s] && (v_rd == r_val);
    wire [31:0] vkey = v_rd ^ 32'h8000_0000;

    // Refuse the add when the list is full, or the value is new and no slot is left.
    wire add_ok = !(r_total >= TCntW'(TotalDepth) ||
                    (!r_found && !r_free_ok && r_used >= DCntW'(DistinctDepth)));
    // Slot for a new value: lowest freed slot, else the next unused one.
    wire [SlotW-1:0] new_slot = r_free_ok ? r_free : r_used[SlotW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_VSCAN;
            ST_VSCAN: if (r_vi >= r_used) n_state = ST_VLAST;
            ST_VLAST: n_state = ST_DONE;
            ST_OSCAN: if (r_oi >= r_total) n_state = ST_OLAST;
            ST_OLAST: n_state = ST_DONE;
            ST_MOVE:  n_state = ST_MOVEW;
            ST_MOVEW: n_state = ST_CSCAN;
            ST_CSCAN: if (r_oi >= r_total) n_state = ST_CLAST;
            ST_CLAST: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        // Branches decided after the value scan.
        if (r_state == ST_VLAST) begin
            if ((r_cmd == CMD_REMOVE || r_cmd == CMD_COUNT) && (r_found || vmatch))
                n_state = ST_OSCAN;
        end
        if (r_state == ST_OLAST && r_cmd == CMD_REMOVE) n_state = ST_MOVE;
    end

    // RAM addressing.
    always_comb begin
        v_ra = r_vi[SlotW-1:0];
        o_ra = r_oi[OccW-1:0];
        if (r_state == ST_MOVE) o_ra = OccW'(r_total - 1'b1);
        v_we = 1'b0; v_wa = new_slot; v_wd = r_val;
        o_we = 1'b0; o_wa = r_pos;  o_wd = o_rd;
        if (r_state == ST_DONE && r_cmd == CMD_ADD && add_ok && !r_found) begin
            v_we = 1'b1;
        end
        if (r_state == ST_DONE && r_cmd == CMD_ADD && add_ok) begin
            o_we = 1'b1;
            o_wa = r_total[OccW-1:0];
            o_wd = r_found ? r_slot : new_slot;
        end
        if (r_state == ST_MOVEW) o_we = 1'b1;   // last occurrence into hole
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_present <= '0;
            r_used    <= '0;
            r_total   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            r_vq <= r_vi;
            r_oq <= r_oi;
            unique case (r_state)
                ST_IDLE: if (accept) begin
                    r_cmd <= i_command; r_val <= i_operand_value;
                    r_vi <= '0; r_oi <= '0; r_vq <= '1;
                    r_found <= 1'b0; r_free_ok <= 1'b0;
                    r_lo <= '1; r_hi <= '0; r_any <= 1'b0; r_cnt <= '0;
                    r_ohit <= 1'b0; r_odrop <= 1'b0; r_oocc <= '0; r_orange <= '0;
                end
                ST_VSCAN, ST_VLAST: begin
                    if (r_state == ST_VSCAN) r_vi <= r_vi + 1'b1;
                    if (r_state == ST_VLAST) r_oq <= '1;
                    if (r_vq != '1 && vq_ok) begin
                        if (vmatch && !r_found) begin
                            r_found <= 1'b1; r_slot <= vq_s;
                        end
                        if (!r_present[vq_s] && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free <= vq_s;
                        end
                        if (r_present[vq_s]) begin
                            r_any <= 1'b1;
                            if (vkey < r_lo) r_lo <= vkey;
                            if (vkey > r_hi) r_hi <= vkey;
                        end
                    end
                end
                ST_OSCAN, ST_OLAST, ST_CSCAN, ST_CLAST: begin
                    if (r_state == ST_OSCAN || r_state == ST_CSCAN) r_oi <= r_oi + 1'b1;
                    if (r_oq != '1 && r_oq < r_total && o_rd == r_slot) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == '0 && (r_state == ST_OSCAN || r_state == ST_OLAST))
                            r_pos <= r_oq[OccW-1:0];
                    end
                end
                ST_MOVE: r_total <= r_total - 1'b1;
                ST_MOVEW: begin
                    r_oi <= '0; r_oq <= '1; r_cnt <= '0;
                end
                default: ;
            endcase
            // Restart the occurrence scan index at the end of the value scan.
            if (r_state == ST_VLAST) r_oi <= '0;
            if (r_state == ST_DONE) begin
                r_ovalid <= 1'b1;
                unique case (r_cmd)
                    CMD_ADD: begin
                        if (!add_ok) begin
                            r_odrop <= 1'b1;
                        end else begin
                            r_total <= r_total + 1'b1;
                            if (!r_found) begin
                                if (r_free_ok) r_present[r_free] <= 1'b1;
                                else begin
                                    r_present[r_used[SlotW-1:0]] <= 1'b1;
                                    r_used <= r_used + 1'b1;
                                end
                            end
                        end
                    end
                    CMD_REMOVE: if (r_found) begin
                        r_ohit <= 1'b1;
                        if (r_cnt == '0) r_present[r_slot] <= 1'b0;
                    end
                    CMD_SEARCH: r_ohit <= r_found;
                    CMD_COUNT:  if (r_found) r_oocc <= 9'(r_cnt);
                    CMD_RANGE: begin
                        if (r_total == '0) r_orange <= '1;
                        else if (r_any && r_lo <= r_hi) r_orange <= {1'b0, r_hi - r_lo};
                        else r_orange <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_hit         = r_ohit;
    assign o_occurrences = r_oocc;
    assign o_total_size  = 9'(r_total);
    assign o_is_empty    = (r_total == '0);
    assign o_value_range = r_orange;
    assign o_add_dropped = r_odrop;
endmodule
